// ===== rtl/core/perspective_point_projection_assert.svh =====
`ifndef PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH
`define PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH

// property checked on the rising clock, ignored while reset is held
`define PPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on the rising clock, reset cycles included
`define PPP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/ppp_pkg.sv =====
`default_nettype none

package ppp_pkg;

  // fixed field widths
  localparam int ROT_W          = 16;
  localparam int ROT_SHIFT      = 12;
  localparam int TR_W           = 20;
  localparam int DIST_W         = 16;
  localparam int OFF_W          = 24;
  localparam int SCR_W          = 24;
  localparam int SCALE_SHIFT    = 8;
  localparam int QUO_W          = 25;
  localparam int ROW_W          = 3 * ROT_W;
  localparam int TRANS_W        = 3 * TR_W;
  localparam int OFFS_W         = 2 * OFF_W;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = TRANS_W;
  localparam int COORD_BITS_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_X     = 3'd0,
    REG_ROT_Y     = 3'd1,
    REG_ROT_Z     = 3'd2,
    REG_TRANS     = 3'd3,
    REG_DIST      = 3'd4,
    REG_OFFSETS   = 3'd5,
    REG_CAM_VALID = 3'd6
  } ppp_reg_e;

  // camera setup shared by front and back
  typedef struct packed {
    logic [ROW_W-1:0]   rot_x;
    logic [ROW_W-1:0]   rot_y;
    logic [ROW_W-1:0]   rot_z;
    logic [TRANS_W-1:0] trans;
    logic [DIST_W-1:0]  proj_dist;
    logic [OFFS_W-1:0]  offs;
    logic               cam;
  } ppp_cfg_t;

  // per-point classification carried through the queue
  typedef struct packed {
    logic visible;
    logic neg_x;
    logic neg_y;
  } ppp_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/perspective_point_projection.sv =====
`default_nettype none

// channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+-------------------------------------
// input    | in        | in_valid_i / in_stall_o      | world_x_i, world_y_i, world_z_i
// result   | out       | out_valid_o / out_stall_i    | visible_o, screen_x_o, screen_y_o
// config   | in        | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// one point is taken per cycle and one result leaves per cycle when nothing stalls
// 32 register stages: 3 front stages, 1 queue slot, multiply, divide entry,
// 25 divider stages (one quotient bit each) and the output register
// reset clears pipeline valids, the queue and all camera registers to zero
// a stalled result holds the back pipeline; the 4-entry queue keeps the front
// accepting until it fills, then in_stall_o rises

module perspective_point_projection #(
  parameter int COORD_BITS = ppp_pkg::COORD_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire signed [COORD_BITS-1:0]          world_x_i,
  input  wire signed [COORD_BITS-1:0]          world_y_i,
  input  wire signed [COORD_BITS-1:0]          world_z_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic                                 visible_o,
  output logic signed [ppp_pkg::SCR_W-1:0]     screen_x_o,
  output logic signed [ppp_pkg::SCR_W-1:0]     screen_y_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire [ppp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire [ppp_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import ppp_pkg::*;

  localparam int AccW  = COORD_BITS + ROT_W + 2;
  localparam int ViewW = ((AccW - ROT_SHIFT > TR_W) ? (AccW - ROT_SHIFT) : TR_W) + 1;
  localparam int QW    = $bits(ppp_flags_t) + 3 * ViewW;

  ppp_cfg_t         cfg_q;
  logic             push, full, pop, empty;
  ppp_flags_t       f_flags, b_flags;
  logic [ViewW-1:0] f_ax, f_ay, f_pz, b_ax, b_ay, b_pz;
  logic [QW-1:0]    q_in, q_out;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (ppp_reg_e'(cfg_index_i))
        REG_ROT_X:     cfg_q.rot_x     <= cfg_data_i[ROW_W-1:0];
        REG_ROT_Y:     cfg_q.rot_y     <= cfg_data_i[ROW_W-1:0];
        REG_ROT_Z:     cfg_q.rot_z     <= cfg_data_i[ROW_W-1:0];
        REG_TRANS:     cfg_q.trans     <= cfg_data_i[TRANS_W-1:0];
        REG_DIST:      cfg_q.proj_dist <= cfg_data_i[DIST_W-1:0];
        REG_OFFSETS:   cfg_q.offs      <= cfg_data_i[OFFS_W-1:0];
        REG_CAM_VALID: cfg_q.cam       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // rotation, translation and classification
  ppp_front #(
    .CoordBits (COORD_BITS),
    .ViewW     (ViewW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .world_x_i  (world_x_i),
    .world_y_i  (world_y_i),
    .world_z_i  (world_z_i),
    .full_i     (full),
    .push_o     (push),
    .flags_o    (f_flags),
    .abs_x_o    (f_ax),
    .abs_y_o    (f_ay),
    .pz_o       (f_pz)
  );

  // decoupling queue
  assign q_in = {f_flags, f_ax, f_ay, f_pz};
  assign {b_flags, b_ax, b_ay, b_pz} = q_out;

  ppp_queue #(
    .DataW (QW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_out)
  );

  // perspective divide and screen mapping
  ppp_back #(
    .ViewW (ViewW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .pop_o       (pop),
    .flags_i     (b_flags),
    .abs_x_i     (b_ax),
    .abs_y_i     (b_ay),
    .pz_i        (b_pz),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .visible_o   (visible_o),
    .screen_x_o  (screen_x_o),
    .screen_y_o  (screen_y_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ppp_front.sv =====
`default_nettype none

module ppp_front #(
  parameter int CoordBits = 16,
  parameter int ViewW     = 23
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  ppp_pkg::ppp_cfg_t            cfg_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire signed [CoordBits-1:0]   world_x_i,
  input  wire signed [CoordBits-1:0]   world_y_i,
  input  wire signed [CoordBits-1:0]   world_z_i,
  input  wire                          full_i,
  output logic                         push_o,
  output ppp_pkg::ppp_flags_t          flags_o,
  output logic [ViewW-1:0]             abs_x_o,
  output logic [ViewW-1:0]             abs_y_o,
  output logic [ViewW-1:0]             pz_o
);
  import ppp_pkg::*;

  localparam int ProdW = CoordBits + ROT_W;
  localparam int AccW  = ProdW + 2;

  logic                     en;
  logic                     v1_q, v2_q, v3_q;
  logic [ROW_W-1:0]         rows [3];
  logic signed [CoordBits-1:0] w [3];
  logic signed [ProdW-1:0]  prod_q [3][3];
  logic signed [AccW-1:0]   acc [3];
  logic signed [ViewW-1:0]  view_d [3];
  logic signed [ViewW-1:0]  view_q [3];
  logic                     vis;
  logic [ViewW-1:0]         half;
  logic [ViewW-1:0]         vz_u;
  ppp_flags_t               flags_q;
  logic [ViewW-1:0]         abs_x_q, abs_y_q, pz_q;

  assign rows[0] = cfg_i.rot_x;
  assign rows[1] = cfg_i.rot_y;
  assign rows[2] = cfg_i.rot_z;
  assign w[0]    = world_x_i;
  assign w[1]    = world_y_i;
  assign w[2]    = world_z_i;

  // pipeline advances unless the last stage is blocked by a full queue
  assign en         = !(v3_q && full_i);
  assign in_stall_o = !en;
  assign push_o     = v3_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 1: nine matrix products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(rows[r][ROT_W*c +: ROT_W]) * w[c];
        end
      end
    end
  end

  // stage 2: row sums, floor shift, translation
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r]    = AccW'(prod_q[r][0]) + AccW'(prod_q[r][1]) + AccW'(prod_q[r][2]);
      view_d[r] = ViewW'($signed(acc[r][AccW-1:ROT_SHIFT]))
                + ViewW'($signed(cfg_i.trans[TR_W*r +: TR_W]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        view_q[r] <= view_d[r];
      end
    end
  end

  // stage 3: visibility, near-plane clamp, magnitudes
  assign vis  = cfg_i.cam && (cfg_i.proj_dist != '0) && !view_q[2][ViewW-1]
             && (view_q[2] != '0);
  assign half = ViewW'(cfg_i.proj_dist[DIST_W-1:1]);
  assign vz_u = view_q[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      flags_q.visible <= vis;
      flags_q.neg_x   <= view_q[0][ViewW-1];
      flags_q.neg_y   <= view_q[1][ViewW-1];
      abs_x_q <= view_q[0][ViewW-1] ? (~view_q[0] + ViewW'(1)) : view_q[0];
      abs_y_q <= view_q[1][ViewW-1] ? (~view_q[1] + ViewW'(1)) : view_q[1];
      pz_q    <= (vz_u > half) ? vz_u : half;
    end
  end

  assign flags_o = flags_q;
  assign abs_x_o = abs_x_q;
  assign abs_y_o = abs_y_q;
  assign pz_o    = pz_q;

endmodule

`default_nettype wire

// ===== rtl/core/ppp_queue.sv =====
`default_nettype none

module ppp_queue #(
  parameter int DataW = 8,
  parameter int Depth = 4
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire [DataW-1:0]  data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             empty_o,
  output logic [DataW-1:0] data_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ppp_back.sv =====
`default_nettype none

module ppp_back #(
  parameter int ViewW = 23
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  ppp_pkg::ppp_cfg_t                  cfg_i,
  input  wire                                empty_i,
  output logic                               pop_o,
  input  ppp_pkg::ppp_flags_t                flags_i,
  input  wire [ViewW-1:0]                    abs_x_i,
  input  wire [ViewW-1:0]                    abs_y_i,
  input  wire [ViewW-1:0]                    pz_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic                               visible_o,
  output logic signed [ppp_pkg::SCR_W-1:0]   screen_x_o,
  output logic signed [ppp_pkg::SCR_W-1:0]   screen_y_o
);
  import ppp_pkg::*;

  localparam int PW   = ViewW + DIST_W;
  localparam int MagW = PW + SCALE_SHIFT;
  localparam int QB   = QUO_W;
  localparam int CmpW = ViewW + QB;
  localparam int SumW = QB + 3;
  localparam logic signed [SumW-1:0] SatMax = SumW'((64'sd1 <<< (SCR_W - 1)) - 64'sd1);
  localparam logic signed [SumW-1:0] SatMin = ~SatMax;

  logic             en;
  logic             vm_q;
  logic [MagW-1:0]  mag_q [2];
  logic [ViewW-1:0] pzm_q;
  ppp_flags_t       flm_q;
  logic [PW-1:0]    px, py;

  logic [CmpW-1:0]  rem_q [2][QB+1];
  logic [QB-1:0]    quo_q [2][QB+1];
  logic             ovf_q [2][QB+1];
  logic [ViewW-1:0] pz_q  [QB+1];
  ppp_flags_t       fl_q  [QB+1];
  logic             v_q   [QB+1];

  logic [QB:0]             quo [2];
  logic signed [QB+1:0]    sq  [2];
  logic signed [SumW-1:0]  sum [2];
  logic [SCR_W-1:0]        res [2];
  logic                    out_valid_q;
  logic                    visible_q;
  logic [SCR_W-1:0]        sx_q, sy_q;

  // whole back pipeline moves unless a finished result is held
  assign en    = !(out_valid_q && out_stall_i);
  assign pop_o = en && !empty_i;

  // scale: magnitude times distance times 256
  assign px = PW'(abs_x_i) * PW'(cfg_i.proj_dist);
  assign py = PW'(abs_y_i) * PW'(cfg_i.proj_dist);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q[0] <= {px, {SCALE_SHIFT{1'b0}}};
      mag_q[1] <= {py, {SCALE_SHIFT{1'b0}}};
      pzm_q    <= pz_i;
      flm_q    <= flags_i;
    end
  end

  // divider entry: overflow check against pz shifted by the quotient width
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[l][0] <= CmpW'(mag_q[l]);
        quo_q[l][0] <= '0;
        ovf_q[l][0] <= CmpW'(mag_q[l]) >= {pzm_q, {QB{1'b0}}};
      end
      pz_q[0] <= pzm_q;
      fl_q[0] <= flm_q;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      for (int s = 0; s <= QB; s++) begin
        v_q[s] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      vm_q   <= !empty_i;
      v_q[0] <= vm_q;
      for (int s = 1; s <= QB; s++) begin
        v_q[s] <= v_q[s-1];
      end
      out_valid_q <= v_q[QB];
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar s = 1; s <= QB; s++) begin : g_div
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [CmpW-1:0] dsh;
      logic            ge;
      assign dsh = CmpW'(pz_q[s-1]) << (QB - s);
      assign ge  = rem_q[l][s-1] >= dsh;

      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[l][s] <= ge ? (rem_q[l][s-1] - dsh) : rem_q[l][s-1];
          quo_q[l][s] <= quo_q[l][s-1] | (QB'(ge) << (QB - s));
          ovf_q[l][s] <= ovf_q[l][s-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pz_q[s] <= pz_q[s-1];
        fl_q[s] <= fl_q[s-1];
      end
    end
  end

  // sign, offset and saturation
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quo[l] = ovf_q[l][QB] ? {1'b1, {QB{1'b0}}} : {1'b0, quo_q[l][QB]};
      if ((l == 0) ? fl_q[QB].neg_x : fl_q[QB].neg_y) begin
        sq[l] = -$signed({1'b0, quo[l]});
      end else begin
        sq[l] = $signed({1'b0, quo[l]});
      end
      sum[l] = SumW'(sq[l]) + SumW'($signed(cfg_i.offs[OFF_W*l +: OFF_W]));
      if (sum[l] > SatMax) begin
        res[l] = SatMax[SCR_W-1:0];
      end else if (sum[l] < SatMin) begin
        res[l] = SatMin[SCR_W-1:0];
      end else begin
        res[l] = sum[l][SCR_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      visible_q <= fl_q[QB].visible;
      sx_q      <= fl_q[QB].visible ? res[0] : '0;
      sy_q      <= fl_q[QB].visible ? res[1] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;

endmodule

`default_nettype wire

// ===== rtl/core/ppp_checker.sv =====
`default_nettype none

`include "perspective_point_projection_assert.svh"

module ppp_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               out_valid_o,
  input wire                               out_stall_i,
  input wire                               visible_o,
  input wire [ppp_pkg::SCR_W-1:0]          screen_x_o,
  input wire [ppp_pkg::SCR_W-1:0]          screen_y_o
);

  // a held result keeps its transaction
  `PPP_ASSERT(a_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(visible_o) && $stable(screen_x_o) && $stable(screen_y_o), "stalled result changed")

  // points that are not projected report the origin
  `PPP_ASSERT(a_zero, out_valid_o && !visible_o |-> screen_x_o == '0 && screen_y_o == '0, "hidden point with nonzero screen position")

  // reset empties the pipeline
  `PPP_ASSERT_RST(a_rst, !rst_ni |=> !out_valid_o, "result valid during reset")

  // no result can be ready right after reset is released
  `PPP_ASSERT(a_rel, $rose(rst_ni) |-> !out_valid_o, "result valid at reset release")

endmodule

bind perspective_point_projection ppp_checker u_ppp_checker (.*);

`default_nettype wire

// ===== dv/ppp_checker.sv =====
`timescale 1ns / 100ps

module ppp_tb_checker
  import ppp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  input  wire                         in_stall_i,
  input  wire signed [COORD_BITS-1:0] world_x_i,
  input  wire signed [COORD_BITS-1:0] world_y_i,
  input  wire signed [COORD_BITS-1:0] world_z_i,
  input  wire                         out_valid_i,
  input  wire                         out_stall_i,
  input  wire                         visible_i,
  input  wire signed [SCR_W-1:0]      screen_x_i,
  input  wire signed [SCR_W-1:0]      screen_y_i,
  input  wire                         cfg_valid_i,
  input  wire                         cfg_ready_i,
  input  wire [CFG_IDX_W-1:0]         cfg_index_i,
  input  wire [CFG_DATA_W-1:0]        cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  localparam longint SCREEN_MAX = 64'sd8388607;
  localparam longint SCREEN_MIN = -64'sd8388608;

  typedef struct packed {
    logic                    visible;
    logic signed [SCR_W-1:0] screen_x;
    logic signed [SCR_W-1:0] screen_y;
  } screen_point_t;

  // local copy of the camera registers
  ppp_cfg_t      camera;
  screen_point_t expected_points[$];

  // one rotated and translated view axis, row sum floored by the q3.12 shift
  function automatic longint view_axis(logic [ROW_W-1:0] row, longint wx, longint wy,
                                       longint wz, longint shift_t);
    longint acc;
    acc = longint'($signed(row[15:0])) * wx + longint'($signed(row[31:16])) * wy
        + longint'($signed(row[47:32])) * wz;
    return (acc >>> ROT_SHIFT) + shift_t;
  endfunction

  // scaled divide truncating toward zero, then offset and clamp
  function automatic logic [SCR_W-1:0] screen_axis(longint v, longint proj_dist, longint pz,
                                                   logic [OFF_W-1:0] offset);
    longint num;
    longint sum;
    num = v * proj_dist * 256;
    sum = longint'($signed(offset)) + num / pz;
    if (sum > SCREEN_MAX) sum = SCREEN_MAX;
    if (sum < SCREEN_MIN) sum = SCREEN_MIN;
    return sum[SCR_W-1:0];
  endfunction

  function automatic screen_point_t project_point(longint wx, longint wy, longint wz);
    screen_point_t pt;
    longint        vx;
    longint        vy;
    longint        vz;
    longint        proj_dist;
    longint        pz;
    pt        = '0;
    proj_dist = longint'(camera.proj_dist);
    if (!camera.cam || proj_dist == 0) return pt;
    vx = view_axis(camera.rot_x, wx, wy, wz, longint'($signed(camera.trans[19:0])));
    vy = view_axis(camera.rot_y, wx, wy, wz, longint'($signed(camera.trans[39:20])));
    vz = view_axis(camera.rot_z, wx, wy, wz, longint'($signed(camera.trans[59:40])));
    if (vz <= 0) return pt;
    // near-plane clamp
    pz = proj_dist >>> 1;
    if (vz > pz) pz = vz;
    pt.visible  = 1'b1;
    pt.screen_x = screen_axis(vx, proj_dist, pz, camera.offs[23:0]);
    pt.screen_y = screen_axis(vy, proj_dist, pz, camera.offs[47:24]);
    return pt;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
    fail_count_o++;
  endtask

  // track config, predict accepted points, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    screen_point_t want;
    if (!rst_ni) begin
      camera       <= '0;
      fail_count_o <= 0;
      pending_o    <= 0;
      expected_points.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ROT_X:     camera.rot_x     <= cfg_data_i[ROW_W-1:0];
          REG_ROT_Y:     camera.rot_y     <= cfg_data_i[ROW_W-1:0];
          REG_ROT_Z:     camera.rot_z     <= cfg_data_i[ROW_W-1:0];
          REG_TRANS:     camera.trans     <= cfg_data_i[TRANS_W-1:0];
          REG_DIST:      camera.proj_dist <= cfg_data_i[DIST_W-1:0];
          REG_OFFSETS:   camera.offs      <= cfg_data_i[OFFS_W-1:0];
          REG_CAM_VALID: camera.cam       <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = expected_points.pop_front();
          if (visible_i !== want.visible)
            report_mismatch("visible", visible_i, want.visible);
          if (screen_x_i !== want.screen_x)
            report_mismatch("screen_x", screen_x_i, want.screen_x);
          if (screen_y_i !== want.screen_y)
            report_mismatch("screen_y", screen_y_i, want.screen_y);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_points.push_back(project_point(world_x_i, world_y_i, world_z_i));
      pending_o <= expected_points.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ppp_pkg::*;

  localparam int                 CW        = COORD_BITS_DEF;
  localparam int                 LATENCY   = 33;
  localparam int                 PHASES    = 8;
  localparam int                 PER_PHASE = 175;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [15:0]        Q12_ONE   = 16'h1000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [CW-1:0]    world_x = '0;
  logic signed [CW-1:0]    world_y = '0;
  logic signed [CW-1:0]    world_z = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    visible;
  logic signed [SCR_W-1:0] screen_x;
  logic signed [SCR_W-1:0] screen_y;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  int                      fail_count;
  int                      pending;
  int                      sender_idle_pct = 34;
  int                      receiver_idle_pct = 64;
  int                      points_sent = 0;

  always #1 clk_i = ~clk_i;

  perspective_point_projection #(.COORD_BITS(CW)) u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .world_x_i(world_x), .world_y_i(world_y), .world_z_i(world_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .visible_o(visible), .screen_x_o(screen_x), .screen_y_o(screen_y),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  ppp_tb_checker #(.COORD_BITS(CW)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .world_x_i(world_x), .world_y_i(world_y), .world_z_i(world_z),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .visible_i(visible), .screen_x_i(screen_x), .screen_y_i(screen_y),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // random receiver stall
  always @(posedge clk_i)
    out_stall <= ($urandom_range(99) < receiver_idle_pct);

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    forever begin
      @(negedge clk_i);
      if (cfg_ready) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop sending and wait until every point has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // camera setup, only once the pipeline has drained
  task automatic load_camera(logic [ROW_W-1:0] rx, logic [ROW_W-1:0] ry,
                             logic [ROW_W-1:0] rz, logic [TRANS_W-1:0] tr,
                             logic [DIST_W-1:0] proj_dist, logic [OFFS_W-1:0] offs,
                             logic cam);
    drain();
    write_reg(REG_ROT_X, CFG_DATA_W'(rx));
    write_reg(REG_ROT_Y, CFG_DATA_W'(ry));
    write_reg(REG_ROT_Z, CFG_DATA_W'(rz));
    write_reg(REG_TRANS, CFG_DATA_W'(tr));
    write_reg(REG_DIST, CFG_DATA_W'(proj_dist));
    write_reg(REG_OFFSETS, CFG_DATA_W'(offs));
    write_reg(REG_CAM_VALID, CFG_DATA_W'(cam));
  endtask

  task automatic send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    world_x  <= x;
    world_y  <= y;
    world_z  <= z;
    forever begin
      @(negedge clk_i);
      if (!in_stall) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    points_sent++;
    // idling profile by progress through the run
    if (points_sent == 500) begin
      sender_idle_pct   = 64;
      receiver_idle_pct = 34;
    end else if (points_sent == 1000) begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
  endtask

  function automatic logic [ROW_W-1:0] random_row(int axis);
    logic [ROW_W-1:0] row;
    row = ROW_W'({$urandom(), $urandom()});
    // mostly near-identity rows with small cross terms
    if ($urandom_range(3) != 0) begin
      row = {3{16'($signed($urandom_range(1023)) - 512)}};
      row[axis*16 +: 16] = Q12_ONE + 16'($urandom_range(2047)) - 16'd1024;
    end
    return row;
  endfunction

  initial begin
    logic [TRANS_W-1:0] tr;
    logic [DIST_W-1:0]  proj_dist;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // camera not yet valid after reset
    send_point(16'h7fff, 16'h8000, 16'h0100);
    send_point(16'h0000, 16'h0000, 16'h0000);

    // identity camera looking down +z
    load_camera({32'h0, Q12_ONE}, {16'h0, Q12_ONE, 16'h0}, {Q12_ONE, 32'h0},
                {20'd100, 20'd0, 20'd0}, 16'd256, 48'h0, 1'b1);
    send_point(16'h0010, 16'hfff0, 16'h0200);   // plain visible point
    send_point(16'h0005, 16'h0005, 16'h0000);   // near-plane clamp
    send_point(16'h0001, 16'h0001, 16'hff9c);   // exactly on the camera plane
    send_point(16'h0000, 16'h0000, 16'h8000);   // behind camera
    send_point(16'h7fff, 16'h8000, 16'hff9d);   // tiny depth, saturates
    send_point(16'h8000, 16'h7fff, 16'h7fff);
    send_point(16'hffff, 16'hffff, 16'h0001);

    // invalid index is ignored, then distance zero
    drain();
    write_reg(REG_UNUSED, {CFG_DATA_W{1'b1}});
    write_reg(REG_DIST, CFG_DATA_W'(0));
    send_point(16'h0010, 16'h0010, 16'h0100);

    // extremes: full-scale rotation, translation, distance and offsets
    load_camera({16'h7fff, 16'h8000, 16'h7fff}, {16'h8000, 16'h7fff, 16'h8000},
                {16'h0000, 16'h0000, 16'h7fff}, {20'h7ffff, 20'h80000, 20'h7ffff},
                16'hffff, {24'h7fffff, 24'h800000}, 1'b1);
    send_point(16'h7fff, 16'h7fff, 16'h7fff);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7fff, 16'h8000, 16'h0000);
    send_point(16'h8000, 16'h7fff, 16'hffff);
    load_camera({16'h8000, 16'h8000, 16'h8000}, {16'h7fff, 16'h7fff, 16'h7fff},
                {16'h8000, 16'h8000, 16'h8000}, {20'h00001, 20'h7ffff, 20'h80000},
                16'd1, {24'h800000, 24'h7fffff}, 1'b1);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7fff, 16'h7fff, 16'h7fff);
    send_point(16'h0001, 16'hffff, 16'h8000);

    // random cameras, mostly usable, with random points
    for (int ph = 0; ph < PHASES; ph++) begin
      tr   = TRANS_W'({$urandom(), $urandom()});
      if ($urandom_range(3) != 0) tr[59:40] = 20'($urandom_range(200000));
      proj_dist = 16'($urandom());
      if (ph == 3) proj_dist = 16'd0;
      else if (ph == 5) proj_dist = 16'hffff;
      else if ($urandom_range(1) == 0) proj_dist = 16'($urandom_range(1023));
      load_camera(random_row(0), random_row(1), random_row(2), tr, proj_dist,
                  OFFS_W'({$urandom(), $urandom()}), (ph != 6));
      for (int i = 0; i < PER_PHASE; i++)
        send_point(16'($urandom()), 16'($urandom()), 16'($urandom()));
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ppp_pkg.sv
rtl/core/ppp_front.sv
rtl/core/ppp_queue.sv
rtl/core/ppp_back.sv
rtl/core/perspective_point_projection.sv
rtl/core/ppp_checker.sv
dv/ppp_checker.sv
dv/tb_top.sv
